/* rtl/wrpm_pkg.sv */
`default_nettype none
package wrpm_pkg;

  // Sizes of the block.
  localparam int WHEEL_COUNT   = 4;
  localparam int CAPTURE_DEPTH = 16;

  // Field and register widths.
  localparam int WHEEL_W      = 2;
  localparam int WHEEL_IDX_W  = $clog2(WHEEL_COUNT);
  localparam int CAP_W        = 16;
  localparam int RPM_W        = 16;
  localparam int FREQ_W       = 32;
  localparam int LIMIT_W      = 8;
  localparam int IDLE_W       = 8;
  localparam int CNT_W        = $clog2(CAPTURE_DEPTH + 1);
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;
  localparam int DIV_CNT_W    = $clog2(FREQ_W);

  // Speed scaling: 0.25 revolutions per capture interval times 60 seconds.
  localparam int RPM_FACTOR   = 15;
  localparam int RPM_MAX      = 65535;
  localparam int RPM_SAT_Q    = RPM_MAX / RPM_FACTOR;
  localparam int SAT_Q_W      = $clog2(RPM_SAT_Q + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_FREQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LIMIT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [FREQ_W-1:0]  TIMER_FREQ_RST = 32'd1000000;
  localparam logic [LIMIT_W-1:0] REST_LIMIT_RST = 8'd14;

  // Request kinds.
  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [WHEEL_W-1:0] wheel;
    logic [CAP_W-1:0]   capture_value;
  } in_req_t;

  typedef struct packed {
    logic [WHEEL_W-1:0] wheel_out;
    logic [RPM_W-1:0]   rpm;
    logic               at_rest;
    logic               updated;
  } out_res_t;

endpackage
`default_nettype wire

/* rtl/wheel_rpm_from_capture_period_unit.sv */
`default_nettype none
// Per-wheel tachometer with stall timeout. Capture requests store a 16-bit
// timer timestamp for one of four wheels; each wheel keeps the newest two of
// up to sixteen captures, and a zero timestamp freezes the wheel until its
// record is next cleared. Capture requests produce no result. A tick
// request returns exactly one result. When the wheel holds two or more
// captures, the speed is 15 * floor(timer_freq / period), saturated to
// 65535, where the period is the 16-bit wrapped difference of the two
// stored timestamps; the quotient comes from a bit-serial restoring divider
// that retires one quotient bit per cycle; such a tick starts the divider,
// waits through its 32 steps, then scales and registers the speed. A tick
// without a division, and a tick with a zero period, delivers its result
// in the cycle after acceptance. Otherwise the
// idle counter advances, and once it has passed rest_limit the speed is
// forced to zero and at_rest is flagged. A result waits in the output
// register until taken; capture requests are still accepted meanwhile, but
// a tick waits until the output register is free. Configuration writes
// (timer_freq at index 0, rest_limit at index 1) should only be issued while
// no tick is in flight.
module wheel_rpm_from_capture_period_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire wrpm_pkg::in_req_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output wrpm_pkg::out_res_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [wrpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wrpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Sequencer: idle, or waiting for the divider of a tick request.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t                                 state_r;

  // Configuration registers.
  logic [wrpm_pkg::FREQ_W-1:0]            timer_freq_r;
  logic [wrpm_pkg::LIMIT_W-1:0]           rest_limit_r;

  // Per-wheel record.
  logic [wrpm_pkg::CNT_W-1:0]             capture_count_r [wrpm_pkg::WHEEL_COUNT];
  logic                                   capture_frozen_r [wrpm_pkg::WHEEL_COUNT];
  logic [wrpm_pkg::CAP_W-1:0]             last_capture_r [wrpm_pkg::WHEEL_COUNT];
  logic [wrpm_pkg::CAP_W-1:0]             previous_capture_r [wrpm_pkg::WHEEL_COUNT];
  logic [wrpm_pkg::IDLE_W-1:0]            idle_ticks_r [wrpm_pkg::WHEEL_COUNT];
  logic [wrpm_pkg::RPM_W-1:0]             held_rpm_r [wrpm_pkg::WHEEL_COUNT];

  // Output register and the wheel of the tick being divided.
  logic                                   out_valid_r;
  wrpm_pkg::out_res_t                     out_data_r;
  logic [wrpm_pkg::WHEEL_W-1:0]           div_wheel_r;

  // Selected wheel's record for the request at the input.
  logic [wrpm_pkg::WHEEL_IDX_W-1:0]       widx;
  logic [wrpm_pkg::WHEEL_IDX_W-1:0]       didx;
  logic                                   in_range;
  logic [wrpm_pkg::CNT_W-1:0]             cnt_sel;
  logic                                   frozen_sel;
  logic [wrpm_pkg::CAP_W-1:0]             period;
  logic [wrpm_pkg::IDLE_W-1:0]            idle_sel;
  logic                                   slot_free;
  logic                                   in_acc;
  logic                                   is_tick;
  logic                                   has_pair;
  logic                                   div_start;
  logic                                   out_set;

  // Divider interface and speed scaling.
  logic                                   div_done;
  logic [wrpm_pkg::FREQ_W-1:0]            div_quo;
  logic [wrpm_pkg::RPM_W-1:0]             rpm_scaled;

  always_comb begin
    widx       = in_data.wheel[wrpm_pkg::WHEEL_IDX_W-1:0];
    didx       = div_wheel_r[wrpm_pkg::WHEEL_IDX_W-1:0];
    in_range   = (int'(in_data.wheel) < wrpm_pkg::WHEEL_COUNT);
    cnt_sel    = capture_count_r[widx];
    frozen_sel = capture_frozen_r[widx];
    idle_sel   = idle_ticks_r[widx];
    period     = last_capture_r[widx] - previous_capture_r[widx];
    is_tick    = (in_data.req_type == wrpm_pkg::REQ_TICK);
    has_pair   = (cnt_sel >= wrpm_pkg::CNT_W'(2));
    slot_free  = !out_valid_r || out_ready;
    // Captures never produce a result, so only ticks wait for the output slot.
    in_ready   = (state_r == S_IDLE) && (!is_tick || slot_free);
    in_acc     = in_valid && in_ready;
    div_start  = in_acc && is_tick && in_range && has_pair && (period != '0);
    // A new result enters the output register in this cycle.
    out_set    = (in_acc && is_tick && !div_start) || ((state_r == S_DIV) && div_done);
  end

  // A quotient above 4369 saturates; below it, q * 15 = q * 16 - q fits in 16 bits.
  always_comb begin
    if (div_quo > wrpm_pkg::FREQ_W'(wrpm_pkg::RPM_SAT_Q)) begin
      rpm_scaled = wrpm_pkg::RPM_W'(wrpm_pkg::RPM_MAX);
    end else begin
      rpm_scaled = wrpm_pkg::RPM_W'({div_quo[wrpm_pkg::SAT_Q_W-1:0], 4'b0000}
                                    - {4'b0000, div_quo[wrpm_pkg::SAT_Q_W-1:0]});
    end
  end

  wrpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (timer_freq_r),
    .divisor  (period),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      timer_freq_r <= wrpm_pkg::TIMER_FREQ_RST;
      rest_limit_r <= wrpm_pkg::REST_LIMIT_RST;
      for (int i = 0; i < wrpm_pkg::WHEEL_COUNT; i++) begin
        capture_count_r[i]    <= '0;
        capture_frozen_r[i]   <= 1'b0;
        last_capture_r[i]     <= '0;
        previous_capture_r[i] <= '0;
        idle_ticks_r[i]       <= '0;
        held_rpm_r[i]         <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wrpm_pkg::CFG_TIMER_FREQ: timer_freq_r <= cfg_data[wrpm_pkg::FREQ_W-1:0];
          wrpm_pkg::CFG_REST_LIMIT: rest_limit_r <= cfg_data[wrpm_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && !out_set) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc && !is_tick) begin
            // Capture request: store unless frozen, full or out of range; a zero stamp freezes the wheel.
            if (in_range && !frozen_sel) begin
              if (in_data.capture_value == '0) begin
                capture_frozen_r[widx] <= 1'b1;
              end else if (cnt_sel < wrpm_pkg::CNT_W'(wrpm_pkg::CAPTURE_DEPTH)) begin
                previous_capture_r[widx] <= last_capture_r[widx];
                last_capture_r[widx]     <= in_data.capture_value;
                capture_count_r[widx]    <= cnt_sel + 1'b1;
              end
            end
          end else if (in_acc) begin
            out_data_r.wheel_out <= in_data.wheel;
            div_wheel_r          <= in_data.wheel;
            if (!in_range) begin
              // A wheel that does not exist reports zero and touches nothing.
              out_data_r.rpm     <= '0;
              out_data_r.at_rest <= 1'b0;
              out_data_r.updated <= 1'b0;
              out_valid_r        <= 1'b1;
            end else if (has_pair) begin
              capture_count_r[widx]    <= '0;
              capture_frozen_r[widx]   <= 1'b0;
              last_capture_r[widx]     <= '0;
              previous_capture_r[widx] <= '0;
              idle_ticks_r[widx]       <= '0;
              out_data_r.at_rest       <= 1'b0;
              if (period == '0) begin
                // Equal timestamps read as the fastest speed.
                held_rpm_r[widx]   <= wrpm_pkg::RPM_W'(wrpm_pkg::RPM_MAX);
                out_data_r.rpm     <= wrpm_pkg::RPM_W'(wrpm_pkg::RPM_MAX);
                out_data_r.updated <= 1'b1;
                out_valid_r        <= 1'b1;
              end else begin
                state_r <= S_DIV;
              end
            end else if (idle_sel <= rest_limit_r) begin
              idle_ticks_r[widx] <= idle_sel + 1'b1;
              out_data_r.rpm     <= held_rpm_r[widx];
              out_data_r.at_rest <= 1'b0;
              out_data_r.updated <= 1'b0;
              out_valid_r        <= 1'b1;
            end else begin
              // Too many idle ticks: the wheel is declared at rest.
              held_rpm_r[widx]         <= '0;
              idle_ticks_r[widx]       <= '0;
              capture_count_r[widx]    <= '0;
              capture_frozen_r[widx]   <= 1'b0;
              last_capture_r[widx]     <= '0;
              previous_capture_r[widx] <= '0;
              out_data_r.rpm           <= '0;
              out_data_r.at_rest       <= 1'b1;
              out_data_r.updated       <= 1'b0;
              out_valid_r              <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            held_rpm_r[didx]   <= rpm_scaled;
            out_data_r.rpm     <= rpm_scaled;
            out_data_r.updated <= 1'b1;
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sequencer is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  // A division finishes only while a tick is waiting for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside of a tick");

  // The output slot is empty whenever a divided tick completes.
  a_slot_free_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !out_valid_r)
    else $error("divided result would overwrite a pending result");

  // A forced stop reports zero speed and no fresh computation.
  a_rest_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.at_rest) |-> (out_data_r.rpm == '0 && !out_data_r.updated))
    else $error("at-rest result carries a speed");

  // No new request is taken while a division is running.
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !in_ready)
    else $error("request accepted during a division");

endmodule
`default_nettype wire

/* rtl/wrpm_div.sv */
`default_nettype none
// Radix-2 restoring divider, one quotient bit per cycle.
module wrpm_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [wrpm_pkg::FREQ_W-1:0]  dividend,
  input  wire logic [wrpm_pkg::CAP_W-1:0]   divisor,
  output logic                              done,
  output logic [wrpm_pkg::FREQ_W-1:0]       quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic [wrpm_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [wrpm_pkg::CAP_W-1:0]        rem_r;
  logic [wrpm_pkg::CAP_W-1:0]        dsr_r;
  logic [wrpm_pkg::FREQ_W-1:0]       quo_r;

  logic [wrpm_pkg::CAP_W:0]          shifted;
  logic [wrpm_pkg::CAP_W:0]          diff;
  logic                              ge;

  // The partial remainder stays below the divisor, so the shifted value
  // is below twice the divisor and one subtract settles each bit.
  always_comb begin
    shifted = {rem_r, quo_r[wrpm_pkg::FREQ_W-1]};
    ge      = (shifted >= {1'b0, dsr_r});
    diff    = shifted - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dsr_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= ge ? diff[wrpm_pkg::CAP_W-1:0] : shifted[wrpm_pkg::CAP_W-1:0];
        quo_r <= {quo_r[wrpm_pkg::FREQ_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == wrpm_pkg::DIV_CNT_W'(wrpm_pkg::FREQ_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

  // Clock and the single reset at the start of the run.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Request channel, result channel and register write port of the block.
  logic in_valid = 1'b0;
  logic in_ready;
  wrpm_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wrpm_pkg::out_res_t out_data;
  logic cfg_we = 1'b0;
  logic [wrpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wrpm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Requests waiting for the driver, and the speed reports still owed by the block.
  wrpm_pkg::in_req_t pending_req_q[$];
  wrpm_pkg::out_res_t expected_speed_q[$];
  int mismatches = 0;

  // Pace of both sides, in percent of cycles spent idle or stalled.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // One long receiver hold-off, counted by the receiver process itself.
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int long_hold_cycles = 0;

  // Our own copy of the configuration, updated alongside each register write.
  logic [wrpm_pkg::FREQ_W-1:0] freq_model = wrpm_pkg::TIMER_FREQ_RST;
  logic [wrpm_pkg::LIMIT_W-1:0] limit_model = wrpm_pkg::REST_LIMIT_RST;

  // Our own copy of the per-wheel capture records.
  logic [wrpm_pkg::CNT_W-1:0] cap_count[wrpm_pkg::WHEEL_COUNT];
  logic frozen[wrpm_pkg::WHEEL_COUNT];
  logic [wrpm_pkg::CAP_W-1:0] last_stamp[wrpm_pkg::WHEEL_COUNT];
  logic [wrpm_pkg::CAP_W-1:0] prev_stamp[wrpm_pkg::WHEEL_COUNT];
  logic [wrpm_pkg::IDLE_W-1:0] idle_ticks[wrpm_pkg::WHEEL_COUNT];
  logic [wrpm_pkg::RPM_W-1:0] held_speed[wrpm_pkg::WHEEL_COUNT];

  wheel_rpm_from_capture_period_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int w = 0; w < wrpm_pkg::WHEEL_COUNT; w++) begin
      cap_count[w] = '0;
      frozen[w] = 1'b0;
      last_stamp[w] = '0;
      prev_stamp[w] = '0;
      idle_ticks[w] = '0;
      held_speed[w] = '0;
    end
  end

  // Applies one accepted request to the wheel records. A capture only updates
  // the record; a tick reports the wheel's speed, either freshly computed from
  // the two newest captures, or the held one while the idle counter runs, or
  // zero once the wheel has been idle for more than rest_limit ticks.
  function automatic void track_wheel_request(wrpm_pkg::in_req_t r);
    wrpm_pkg::out_res_t res;
    logic [wrpm_pkg::CAP_W-1:0] period;
    logic [wrpm_pkg::FREQ_W-1:0] quot;
    logic [47:0] scaled;
    int w;
    w = r.wheel;
    if (r.req_type == wrpm_pkg::REQ_CAPTURE) begin
      if (w >= wrpm_pkg::WHEEL_COUNT || frozen[w]) return;
      // A zero timestamp marks a lost edge: the wheel ignores captures until cleared.
      if (r.capture_value == '0) begin
        frozen[w] = 1'b1;
        return;
      end
      if (cap_count[w] >= wrpm_pkg::CAPTURE_DEPTH) return;
      prev_stamp[w] = last_stamp[w];
      last_stamp[w] = r.capture_value;
      cap_count[w] = cap_count[w] + 1'b1;
      return;
    end
    res = '0;
    res.wheel_out = r.wheel;
    if (w < wrpm_pkg::WHEEL_COUNT) begin
      if (cap_count[w] >= 2) begin
        // The period wraps modulo 2^16, just like the free-running capture timer.
        period = last_stamp[w] - prev_stamp[w];
        if (period == '0) begin
          held_speed[w] = wrpm_pkg::RPM_W'(wrpm_pkg::RPM_MAX);
        end else begin
          quot = freq_model / wrpm_pkg::FREQ_W'(period);
          scaled = 48'(quot) * 48'(wrpm_pkg::RPM_FACTOR);
          held_speed[w] = (scaled > 48'(wrpm_pkg::RPM_MAX)) ?
                          wrpm_pkg::RPM_W'(wrpm_pkg::RPM_MAX) : scaled[wrpm_pkg::RPM_W-1:0];
        end
        idle_ticks[w] = '0;
        res.updated = 1'b1;
        cap_count[w] = '0;
        frozen[w] = 1'b0;
        last_stamp[w] = '0;
        prev_stamp[w] = '0;
      end else if (idle_ticks[w] <= limit_model) begin
        // With rest_limit at its maximum this wraps and the wheel never rests.
        idle_ticks[w] = idle_ticks[w] + 1'b1;
      end else begin
        held_speed[w] = '0;
        idle_ticks[w] = '0;
        res.at_rest = 1'b1;
        cap_count[w] = '0;
        frozen[w] = 1'b0;
        last_stamp[w] = '0;
        prev_stamp[w] = '0;
      end
      res.rpm = held_speed[w];
    end
    expected_speed_q.push_back(res);
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Driver: presents the next pending request once the previous one has been
  // taken, sometimes leaving a gap first. A request stays put until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_req_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls at the current pace, plus one long hold-off when
  // requested, long enough for the output register to fill and for a waiting
  // tick to push back on the request channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      out_ready <= 1'b0;
      long_hold_cycles <= long_hold_cycles + 1;
      if (long_hold_cycles == 400)
        long_hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: every accepted request feeds the predictor, every accepted result
  // is checked against the oldest expected speed report.
  always @(posedge clk) begin
    wrpm_pkg::out_res_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        track_wheel_request(in_data);
      if (out_valid && out_ready) begin
        if (expected_speed_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
        end else begin
          want = expected_speed_q.pop_front();
          check_field("wheel_out", 32'(want.wheel_out), 32'(out_data.wheel_out));
          check_field("rpm", 32'(want.rpm), 32'(out_data.rpm));
          check_field("at_rest", 32'(want.at_rest), 32'(out_data.at_rest));
          check_field("updated", 32'(want.updated), 32'(out_data.updated));
        end
      end
    end
  end

  task automatic add_req(logic kind, logic [wrpm_pkg::WHEEL_W-1:0] wheel,
                         logic [wrpm_pkg::CAP_W-1:0] value);
    wrpm_pkg::in_req_t r;
    r.req_type = kind;
    r.wheel = wheel;
    r.capture_value = value;
    pending_req_q.push_back(r);
  endtask

  // Waits until every request is sent and every report is back, then lets the
  // block finish any capture or division still inside it.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_req_q.size() != 0 || in_valid || expected_speed_q.size() != 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Sets the pace of both sides and rewrites both registers while the block is idle.
  task automatic start_phase(int send_pct, int recv_pct, logic [wrpm_pkg::FREQ_W-1:0] freq,
                             logic [wrpm_pkg::LIMIT_W-1:0] limit);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= wrpm_pkg::CFG_TIMER_FREQ;
    cfg_data <= freq;
    freq_model <= freq;
    @(posedge clk);
    cfg_index <= wrpm_pkg::CFG_REST_LIMIT;
    cfg_data <= wrpm_pkg::CFG_DATA_W'(limit);
    limit_model <= limit;
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Random traffic, mostly well-formed: a few captures on one wheel with a
  // chosen period, then a tick for that wheel. Some bursts overrun the record,
  // some carry a zero timestamp, some are bare ticks that run the idle counter,
  // and the rest are fully random requests.
  task automatic add_random_traffic(int target);
    int added;
    int n;
    int w;
    int roll;
    logic [wrpm_pkg::CAP_W-1:0] stamp;
    logic [wrpm_pkg::CAP_W-1:0] period;
    added = 0;
    while (added < target) begin
      w = $urandom_range(wrpm_pkg::WHEEL_COUNT - 1);
      roll = $urandom_range(99);
      if (roll < 70) begin
        n = ($urandom_range(9) == 0) ?
            $urandom_range(wrpm_pkg::CAPTURE_DEPTH, wrpm_pkg::CAPTURE_DEPTH + 3) :
            $urandom_range(2, 4);
        stamp = wrpm_pkg::CAP_W'($urandom);
        case ($urandom_range(4))
          0: period = '0;
          1: period = wrpm_pkg::CAP_W'($urandom_range(1, 64));
          2: period = wrpm_pkg::CAP_W'($urandom_range(200, 8000));
          3: period = wrpm_pkg::CAP_W'($urandom_range(60000, 65535));
          default: period = wrpm_pkg::CAP_W'($urandom);
        endcase
        for (int i = 0; i < n; i++) begin
          add_req(wrpm_pkg::REQ_CAPTURE, wrpm_pkg::WHEEL_W'(w),
                  ($urandom_range(19) == 0) ? '0 : stamp);
          stamp = stamp + period;
        end
        add_req(wrpm_pkg::REQ_TICK, wrpm_pkg::WHEEL_W'(w), wrpm_pkg::CAP_W'($urandom));
        added += n + 1;
      end else if (roll < 85) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          add_req(wrpm_pkg::REQ_TICK, wrpm_pkg::WHEEL_W'(w), wrpm_pkg::CAP_W'($urandom));
        added += n;
      end else begin
        add_req(1'($urandom_range(1)),
                wrpm_pkg::WHEEL_W'($urandom_range(wrpm_pkg::WHEEL_COUNT - 1)),
                wrpm_pkg::CAP_W'($urandom));
        added++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset configuration, with no idling on either side.
    @(negedge clk);
    // A tick with no captures only advances the idle counter.
    add_req(wrpm_pkg::REQ_TICK, 2'd0, 16'hFFFF);
    // Smallest and largest nonzero stamps: the period is 0xFFFE.
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd1, 16'h0001);
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd1, 16'hFFFF);
    add_req(wrpm_pkg::REQ_TICK, 2'd1, 16'h0000);
    // Two equal stamps give a zero period and the top speed.
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd2, 16'h1234);
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd2, 16'h1234);
    add_req(wrpm_pkg::REQ_TICK, 2'd2, 16'h0000);
    // A short period saturates the scaled quotient.
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd3, 16'd100);
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd3, 16'd110);
    add_req(wrpm_pkg::REQ_TICK, 2'd3, 16'h0000);
    // Stamps across the timer rollover give an ordinary speed.
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd1, 16'hFF00);
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd1, 16'h0F00);
    add_req(wrpm_pkg::REQ_TICK, 2'd1, 16'h5A5A);
    // A zero stamp freezes the wheel, so the later captures are ignored.
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd0, 16'h0000);
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd0, 16'd500);
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd0, 16'd1000);
    add_req(wrpm_pkg::REQ_TICK, 2'd0, 16'hA5A5);
    // A single capture is not enough for a speed.
    add_req(wrpm_pkg::REQ_CAPTURE, 2'd2, 16'h8000);
    add_req(wrpm_pkg::REQ_TICK, 2'd2, 16'h0000);
    wait_drained();

    // Slowest timer and the smallest rest limit: nearly every computed speed is zero.
    start_phase(0, 0, 32'd1, 8'd0);
    add_random_traffic(25);
    wait_drained();

    // Fastest timer and the largest limit. A long run of bare ticks on one
    // wheel makes its idle counter wrap without the wheel ever resting.
    start_phase(59, 0, 32'hFFFF_FFFF, 8'hFF);
    for (int i = 0; i < 260; i++)
      add_req(wrpm_pkg::REQ_TICK, 2'd3, wrpm_pkg::CAP_W'($urandom));
    add_random_traffic(20);
    wait_drained();

    start_phase(0, 59, wrpm_pkg::FREQ_W'($urandom_range(50000, 5000000)),
                wrpm_pkg::LIMIT_W'($urandom_range(1, 20)));
    add_random_traffic(25);
    wait_drained();

    // Both sides idle now and then; halfway through, the sender pauses until
    // every report has come back.
    start_phase(15, 15, 32'd32768, 8'd3);
    add_random_traffic(15);
    wait_drained();
    @(negedge clk);
    add_random_traffic(15);
    wait_drained();

    // Back to the reset values while the receiver holds off for a long time.
    start_phase(0, 0, wrpm_pkg::TIMER_FREQ_RST, wrpm_pkg::REST_LIMIT_RST);
    @(posedge clk);
    long_hold_req <= 1'b1;
    @(negedge clk);
    add_random_traffic(25);
    wait_drained();

    if (mismatches == 0 && expected_speed_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
